// ===== src/aabb_collision_event_tracker_unit_macros.svh =====
// Assertion macros for the collision event tracker.
// Each expects clk_i and rst_ni in the scope of the module that uses it.
`ifndef AABB_COLLISION_EVENT_TRACKER_UNIT_MACROS_SVH
`define AABB_COLLISION_EVENT_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AABB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aabb tracker check failed");

// next-cycle implication
`define AABB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aabb tracker check failed");

`else

`define AABB_ASSERT_NOW(label, ante, cons)
`define AABB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/aabb_cet_pkg.sv =====
package aabb_cet_pkg;

  localparam int COORD_BITS    = 16;
  localparam int ID_BITS       = 4;
  localparam int MAX_COLLIDERS = 1 << ID_BITS;
  localparam int PAIR_BITS     = 2 * ID_BITS;
  localparam int NUM_PAIRS     = MAX_COLLIDERS * MAX_COLLIDERS;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } contact_event_e;

endpackage

// ===== src/aabb_cet_axis.sv =====
// One axis of the box test: 2*|pos_b - pos_a| <= size_a + size_b.
module aabb_cet_axis
  import aabb_cet_pkg::*;
(
  input  logic signed [COORD_BITS-1:0] pos_a_i,
  input  logic signed [COORD_BITS-1:0] pos_b_i,
  input  logic        [COORD_BITS-1:0] size_a_i,
  input  logic        [COORD_BITS-1:0] size_b_i,
  output logic                         hit_o
);

  logic signed [COORD_BITS:0]   diff;
  logic        [COORD_BITS:0]   mag;
  logic        [COORD_BITS+1:0] twice;
  logic        [COORD_BITS:0]   sum;

  always_comb begin
    diff  = {pos_b_i[COORD_BITS-1], pos_b_i} - {pos_a_i[COORD_BITS-1], pos_a_i};
    // most negative difference negates to its unsigned magnitude, still exact
    mag   = diff[COORD_BITS] ? (COORD_BITS+1)'(0) - diff : diff;
    twice = {mag, 1'b0};
    sum   = {1'b0, size_a_i} + {1'b0, size_b_i};
    hit_o = (twice <= {1'b0, sum});
  end

endmodule

// ===== src/aabb_collision_event_tracker_unit.sv =====
// Pipeline: an accepted item is held in the input register, then its result is
// registered and shown on the result ports for one cycle, flagged by result_valid_o.
// Throughput: one item per cycle while busy_o is low; input register, overlap
// test plus contact-bit read-modify-write, result register. The receiver cannot
// stall results. Reset: asynchronous; clears the pipeline, then a pass over all
// NUM_PAIRS (256) entries zeroes the contact table while busy_o is high.
`include "aabb_collision_event_tracker_unit_macros.svh"

module aabb_collision_event_tracker_unit
  import aabb_cet_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic        [ID_BITS-1:0]    left_id_i,
  input  logic        [ID_BITS-1:0]    right_id_i,
  input  logic signed [COORD_BITS-1:0] left_x_i,
  input  logic signed [COORD_BITS-1:0] left_y_i,
  input  logic        [COORD_BITS-1:0] left_w_i,
  input  logic        [COORD_BITS-1:0] left_h_i,
  input  logic signed [COORD_BITS-1:0] right_x_i,
  input  logic signed [COORD_BITS-1:0] right_y_i,
  input  logic        [COORD_BITS-1:0] right_w_i,
  input  logic        [COORD_BITS-1:0] right_h_i,
  input  logic                         left_dying_i,
  input  logic                         right_dying_i,
  output logic                         result_valid_o,
  output logic        [1:0]            contact_event_o,
  output logic                         boxes_overlap_o
);

  logic                         accept;

  // input register
  logic                         s1_valid_q;
  logic        [ID_BITS-1:0]    lid_q, rid_q;
  logic signed [COORD_BITS-1:0] lx_q, ly_q, rx_q, ry_q;
  logic        [COORD_BITS-1:0] lw_q, lh_q, rw_q, rh_q;
  logic                         dying_q;

  // contact table, one bit per ordered pair
  logic                         contact_mem [NUM_PAIRS];
  logic [PAIR_BITS-1:0]         rd_idx;
  logic                         prev_q;
  logic                         wr_en;
  logic                         wr_bit;

  // clearing pass after reset
  logic                         clr_busy_q;
  logic [PAIR_BITS-1:0]         clr_idx_q;

  logic                         hit_x, hit_y, hit;
  logic [PAIR_BITS-1:0]         pair_idx;
  contact_event_e               event_d;

  // result register
  logic                         res_valid_q;
  contact_event_e               event_q;
  logic                         overlap_q;

  assign busy_o = clr_busy_q;
  assign accept = start_i & ~busy_o;
  assign rd_idx = {left_id_i, right_id_i};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lid_q   <= left_id_i;
      rid_q   <= right_id_i;
      lx_q    <= left_x_i;
      ly_q    <= left_y_i;
      lw_q    <= left_w_i;
      lh_q    <= left_h_i;
      rx_q    <= right_x_i;
      ry_q    <= right_y_i;
      rw_q    <= right_w_i;
      rh_q    <= right_h_i;
      dying_q <= left_dying_i | right_dying_i;
    end
  end

  aabb_cet_axis u_axis_x (
    .pos_a_i  (lx_q),
    .pos_b_i  (rx_q),
    .size_a_i (lw_q),
    .size_b_i (rw_q),
    .hit_o    (hit_x)
  );

  aabb_cet_axis u_axis_y (
    .pos_a_i  (ly_q),
    .pos_b_i  (ry_q),
    .size_a_i (lh_q),
    .size_b_i (rh_q),
    .hit_o    (hit_y)
  );

  assign hit      = hit_x & hit_y;
  assign pair_idx = {lid_q, rid_q};

  always_comb begin
    event_d = EV_NONE;
    wr_en   = 1'b0;
    wr_bit  = 1'b0;
    // a collider paired with itself never writes the table and gives no event
    if (s1_valid_q && (lid_q != rid_q)) begin
      if (hit) begin
        if (prev_q) begin
          if (dying_q) begin
            event_d = EV_EXIT;
            wr_en   = 1'b1;
            wr_bit  = 1'b0;
          end else begin
            event_d = EV_STAY;
          end
        end else if (!dying_q) begin
          event_d = EV_ENTER;
          wr_en   = 1'b1;
          wr_bit  = 1'b1;
        end
      end else if (prev_q) begin
        event_d = EV_EXIT;
        wr_en   = 1'b1;
        wr_bit  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      contact_mem[clr_idx_q] <= 1'b0;
    end else if (wr_en) begin
      contact_mem[pair_idx] <= wr_bit;
    end
    if (accept) begin
      // the item in flight to the same pair hands its new bit forward
      prev_q <= (wr_en && (rd_idx == pair_idx)) ? wr_bit : contact_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
    end else begin
      s1_valid_q  <= accept;
      res_valid_q <= s1_valid_q;
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == PAIR_BITS'(NUM_PAIRS - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      event_q   <= event_d;
      overlap_q <= hit;
    end
  end

  assign result_valid_o  = res_valid_q;
  assign contact_event_o = event_q;
  assign boxes_overlap_o = overlap_q;

  `AABB_ASSERT_NEXT(a_item_gives_result, s1_valid_q, result_valid_o)
  `AABB_ASSERT_NEXT(a_self_pair_none, s1_valid_q && (lid_q == rid_q),
                    contact_event_o == EV_NONE)
  `AABB_ASSERT_NOW(a_enter_needs_overlap,
                   result_valid_o && (contact_event_o == EV_ENTER), boxes_overlap_o)
  `AABB_ASSERT_NOW(a_stay_needs_overlap,
                   result_valid_o && (contact_event_o == EV_STAY), boxes_overlap_o)
  `AABB_ASSERT_NOW(a_idle_while_clearing, clr_busy_q, !s1_valid_q && !result_valid_o)

endmodule
